// ----- rtl/wph_pkg.sv -----
// Shared constants, types and helper functions for the wave pillar height block.
// No dependencies; every other file imports this package.
package wph_pkg;

  // Grid and field widths
  localparam int GRID_DIM   = 32;
  localparam int IDX_W      = 5;
  localparam int TIME_W     = 24;
  localparam int SPC_W      = 16;
  localparam int PAT_W      = 3;
  localparam int HGT_W      = 14;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  // Centred index, coordinate, radius widths
  localparam int CENT_W  = ((GRID_DIM > 64) ? $clog2(GRID_DIM) : 6) + 2;
  localparam int COORD_W = CENT_W + SPC_W;
  localparam int CS_W    = COORD_W + 1;
  localparam int SQ_W    = 2 * COORD_W;
  localparam int ROOT_W  = COORD_W;
  localparam int ATN_W   = COORD_W + 2;

  // Phase and CORDIC
  localparam int PH_W       = 32;
  localparam int CRD_STEPS  = 16;
  localparam int SC_W       = 28;
  localparam int SA_W       = PH_W + 2;
  localparam int UNIT_W     = 18;
  localparam int H_W        = 36;
  localparam int WIDE_W     = 40;
  localparam int COORD_FRAC = 17;
  localparam int TIME_FRAC  = 16;

  localparam logic [PH_W-1:0] HALF_U32 = PH_W'(1) << (PH_W - 1);
  localparam logic signed [SA_W-1:0] QUARTER_TURN = SA_W'(1) <<< (PH_W - 2);
  localparam logic signed [SA_W-1:0] HALF_TURN    = SA_W'(1) <<< (PH_W - 1);
  localparam logic signed [SC_W-1:0] CORDIC_GAIN  = SC_W'(10188014);
  localparam logic signed [WIDE_W-1:0] ONE_Q16    = WIDE_W'(65536);

  // Phase constants: round(c * 2^32 / (2*pi))
  localparam logic [PH_W-1:0] K_2_0 = 32'd1367130551;
  localparam logic [PH_W-1:0] K_3_0 = 32'd2050695827;
  localparam logic [PH_W-1:0] K_1_5 = 32'd1025347913;
  localparam logic [PH_W-1:0] K_2_5 = 32'd1708913189;
  localparam logic [PH_W-1:0] K_1_2 = 32'd820278331;
  localparam logic [PH_W-1:0] K_0_5 = 32'd341782638;
  localparam logic [PH_W-1:0] K_3_1 = 32'd2119052354;
  localparam logic [PH_W-1:0] K_1_7 = 32'd1162060968;
  localparam logic [PH_W-1:0] K_2_7 = 32'd1845626244;
  localparam logic [PH_W-1:0] K_2_3 = 32'd1572200134;
  localparam logic [PH_W-1:0] K_1_9 = 32'd1298774024;

  // Pattern codes
  localparam logic [PAT_W-1:0] PAT_RIPPLE   = 3'd1;
  localparam logic [PAT_W-1:0] PAT_DIAGONAL = 3'd2;
  localparam logic [PAT_W-1:0] PAT_SPIRAL   = 3'd3;
  localparam logic [PAT_W-1:0] PAT_CROSS    = 3'd4;
  localparam logic [PAT_W-1:0] PAT_BREATH   = 3'd5;
  localparam logic [PAT_W-1:0] PAT_LAYERED  = 3'd6;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_PATTERN = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SPACING = 2'd1;

  localparam logic [SPC_W-1:0] SPACING_RST = 16'd29491;

  typedef struct packed {
    logic signed [COORD_W-1:0] cx;
    logic signed [COORD_W-1:0] cz;
    logic signed [CS_W-1:0]    cs;
    logic [TIME_W-1:0]         t;
  } item_t;

  typedef struct packed {
    item_t             it;
    logic [ROOT_W-1:0] d;
  } geo_t;

  // atan(2^-i) in turns
  function automatic logic [PH_W-1:0] atan_turn(input logic [3:0] i);
    case (i)
      4'd0:    return 32'd536870912;
      4'd1:    return 32'd316933406;
      4'd2:    return 32'd167458907;
      4'd3:    return 32'd85004756;
      4'd4:    return 32'd42667331;
      4'd5:    return 32'd21354465;
      4'd6:    return 32'd10679838;
      4'd7:    return 32'd5340245;
      4'd8:    return 32'd2670163;
      4'd9:    return 32'd1335087;
      4'd10:   return 32'd667544;
      4'd11:   return 32'd333772;
      4'd12:   return 32'd166886;
      4'd13:   return 32'd83443;
      4'd14:   return 32'd41722;
      4'd15:   return 32'd20861;
      default: return '0;
    endcase
  endfunction

  // Saturate to [-1, 1] in Q16
  function automatic logic signed [UNIT_W-1:0] clamp_unit(input logic signed [WIDE_W-1:0] v);
    if (v > ONE_Q16) return UNIT_W'(65536);
    if (v < -ONE_Q16) return -UNIT_W'(65536);
    return v[UNIT_W-1:0];
  endfunction

endpackage

// ----- rtl/wph_if.sv -----
// Handshake interfaces for the wave pillar height block: item in, height out, config.
// Depends on wph_pkg.
interface wph_in_if
  import wph_pkg::*;
();
  logic              valid;
  logic              ready;
  logic [IDX_W-1:0]  column_index;
  logic [IDX_W-1:0]  row_index;
  logic [TIME_W-1:0] time_value;
  modport source (output valid, column_index, row_index, time_value, input ready);
  modport sink   (input valid, column_index, row_index, time_value, output ready);
endinterface

interface wph_out_if
  import wph_pkg::*;
();
  logic             valid;
  logic             ready;
  logic [HGT_W-1:0] pillar_height;
  modport source (output valid, pillar_height, input ready);
  modport sink   (input valid, pillar_height, output ready);
endinterface

interface wph_cfg_if
  import wph_pkg::*;
();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ----- rtl/wph_isqrt.sv -----
// Pipelined integer square root, one result bit per stage, sideband carried along.
// Depends on wph_pkg.
module wph_isqrt
  import wph_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              en_i,
  input  logic              vld_i,
  input  logic [SQ_W-1:0]   rad_i,
  input  item_t             side_i,
  output logic              vld_o,
  output logic [ROOT_W-1:0] root_o,
  output item_t             side_o
);

  logic            vld_q  [ROOT_W];
  logic [SQ_W-1:0] rem_q  [ROOT_W];
  logic [SQ_W-1:0] res_q  [ROOT_W];
  item_t           side_q [ROOT_W];

  for (genvar k = 0; k < ROOT_W; k++) begin : g_step
    localparam logic [SQ_W-1:0] StepBit = SQ_W'(1) << (2 * (ROOT_W - 1 - k));
    logic            vld_in;
    logic [SQ_W-1:0] rem_in;
    logic [SQ_W-1:0] res_in;
    logic [SQ_W-1:0] trial;
    item_t           side_in;

    if (k == 0) begin : g_first
      assign vld_in  = vld_i;
      assign rem_in  = rad_i;
      assign res_in  = '0;
      assign side_in = side_i;
    end else begin : g_next
      assign vld_in  = vld_q[k-1];
      assign rem_in  = rem_q[k-1];
      assign res_in  = res_q[k-1];
      assign side_in = side_q[k-1];
    end

    assign trial = res_in + StepBit;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[k] <= 1'b0;
      end else if (en_i) begin
        vld_q[k] <= vld_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        side_q[k] <= side_in;
        if (rem_in >= trial) begin
          rem_q[k] <= rem_in - trial;
          res_q[k] <= (res_in >> 1) + StepBit;
        end else begin
          rem_q[k] <= rem_in;
          res_q[k] <= res_in >> 1;
        end
      end
    end
  end

  assign vld_o  = vld_q[ROOT_W-1];
  assign root_o = res_q[ROOT_W-1][ROOT_W-1:0];
  assign side_o = side_q[ROOT_W-1];

endmodule

// ----- rtl/wph_atan.sv -----
// Pipelined vectoring CORDIC: angle of (cx, cz) in turns, sideband carried along.
// Depends on wph_pkg.
module wph_atan
  import wph_pkg::*;
(
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            en_i,
  input  logic            vld_i,
  input  geo_t            geo_i,
  output logic            vld_o,
  output geo_t            geo_o,
  output logic [PH_W-1:0] ang_o
);

  logic                    vld_q  [CRD_STEPS+1];
  logic                    zero_q [CRD_STEPS+1];
  logic signed [ATN_W-1:0] x_q    [CRD_STEPS+1];
  logic signed [ATN_W-1:0] y_q    [CRD_STEPS+1];
  logic [PH_W-1:0]         z_q    [CRD_STEPS+1];
  geo_t                    geo_q  [CRD_STEPS+1];

  logic signed [ATN_W-1:0] x_in;
  logic signed [ATN_W-1:0] y_in;

  assign x_in = ATN_W'(geo_i.it.cx);
  assign y_in = ATN_W'(geo_i.it.cz);

  // Turn the left half plane by half a turn
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q[0] <= 1'b0;
    end else if (en_i) begin
      vld_q[0] <= vld_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      geo_q[0]  <= geo_i;
      zero_q[0] <= (x_in == '0) && (y_in == '0);
      if (x_in < 0) begin
        x_q[0] <= -x_in;
        y_q[0] <= -y_in;
        z_q[0] <= HALF_U32;
      end else begin
        x_q[0] <= x_in;
        y_q[0] <= y_in;
        z_q[0] <= '0;
      end
    end
  end

  for (genvar i = 0; i < CRD_STEPS; i++) begin : g_step
    localparam logic [PH_W-1:0] StepAtan = atan_turn(4'(i));
    logic signed [ATN_W-1:0] dx;
    logic signed [ATN_W-1:0] dy;

    assign dx = y_q[i] >>> i;
    assign dy = x_q[i] >>> i;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[i+1] <= 1'b0;
      end else if (en_i) begin
        vld_q[i+1] <= vld_q[i];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        geo_q[i+1]  <= geo_q[i];
        zero_q[i+1] <= zero_q[i];
        if (y_q[i] > 0) begin
          x_q[i+1] <= x_q[i] + dx;
          y_q[i+1] <= y_q[i] - dy;
          z_q[i+1] <= z_q[i] + StepAtan;
        end else begin
          x_q[i+1] <= x_q[i] - dx;
          y_q[i+1] <= y_q[i] + dy;
          z_q[i+1] <= z_q[i] - StepAtan;
        end
      end
    end
  end

  // The origin has no direction: report zero turns
  assign vld_o = vld_q[CRD_STEPS];
  assign geo_o = geo_q[CRD_STEPS];
  assign ang_o = zero_q[CRD_STEPS] ? '0 : z_q[CRD_STEPS];

endmodule

// ----- rtl/wph_sincos.sv -----
// Pipelined rotation CORDIC: sine and cosine of a phase in turns, Q16 results.
// Depends on wph_pkg.
module wph_sincos
  import wph_pkg::*;
(
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     en_i,
  input  logic                     vld_i,
  input  logic [PH_W-1:0]          ph_i,
  output logic                     vld_o,
  output logic signed [UNIT_W-1:0] sin_o,
  output logic signed [UNIT_W-1:0] cos_o
);

  logic                   vld_q  [CRD_STEPS+1];
  logic                   flip_q [CRD_STEPS+1];
  logic signed [SC_W-1:0] x_q    [CRD_STEPS+1];
  logic signed [SC_W-1:0] y_q    [CRD_STEPS+1];
  logic signed [SA_W-1:0] a_q    [CRD_STEPS+1];

  logic signed [SA_W-1:0] a_in;
  logic signed [SA_W-1:0] a_fold;
  logic                   flip_in;

  logic                     vld_out_q;
  logic signed [UNIT_W-1:0] sin_q;
  logic signed [UNIT_W-1:0] cos_q;
  logic signed [SC_W-1:0]   x_rnd;
  logic signed [SC_W-1:0]   y_rnd;
  logic signed [UNIT_W-1:0] cos_c;

  // Fold into the right half plane, remember to flip the cosine
  always_comb begin
    a_in    = $signed({{(SA_W-PH_W){ph_i[PH_W-1]}}, ph_i});
    a_fold  = a_in;
    flip_in = 1'b0;
    if (a_in > QUARTER_TURN) begin
      a_fold  = HALF_TURN - a_in;
      flip_in = 1'b1;
    end else if (a_in < -QUARTER_TURN) begin
      a_fold  = -HALF_TURN - a_in;
      flip_in = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q[0] <= 1'b0;
    end else if (en_i) begin
      vld_q[0] <= vld_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      x_q[0]    <= CORDIC_GAIN;
      y_q[0]    <= '0;
      a_q[0]    <= a_fold;
      flip_q[0] <= flip_in;
    end
  end

  for (genvar i = 0; i < CRD_STEPS; i++) begin : g_step
    localparam logic signed [SA_W-1:0] StepAtan = $signed({2'b00, atan_turn(4'(i))});
    logic signed [SC_W-1:0] dx;
    logic signed [SC_W-1:0] dy;

    assign dx = y_q[i] >>> i;
    assign dy = x_q[i] >>> i;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[i+1] <= 1'b0;
      end else if (en_i) begin
        vld_q[i+1] <= vld_q[i];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        flip_q[i+1] <= flip_q[i];
        if (a_q[i] >= 0) begin
          x_q[i+1] <= x_q[i] - dx;
          y_q[i+1] <= y_q[i] + dy;
          a_q[i+1] <= a_q[i] - StepAtan;
        end else begin
          x_q[i+1] <= x_q[i] + dx;
          y_q[i+1] <= y_q[i] - dy;
          a_q[i+1] <= a_q[i] + StepAtan;
        end
      end
    end
  end

  // Round Q24 to Q16 and saturate
  assign x_rnd = (x_q[CRD_STEPS] + SC_W'(128)) >>> 8;
  assign y_rnd = (y_q[CRD_STEPS] + SC_W'(128)) >>> 8;
  assign cos_c = clamp_unit(WIDE_W'(x_rnd));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_out_q <= 1'b0;
    end else if (en_i) begin
      vld_out_q <= vld_q[CRD_STEPS];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sin_q <= clamp_unit(WIDE_W'(y_rnd));
      cos_q <= flip_q[CRD_STEPS] ? -cos_c : cos_c;
    end
  end

  assign vld_o = vld_out_q;
  assign sin_o = sin_q;
  assign cos_o = cos_q;

endmodule

// ----- rtl/wave_pillar_height.sv -----
// Wave pillar height: one animated pillar height per grid position and time.
// Depends on wph_pkg, wph_if, wph_isqrt, wph_atan and wph_sincos.
//
// Usage
//   in_if  : column_index, row_index, time_value (Q8.16 s); one transfer per item.
//   out_if : pillar_height, unsigned Q2.12 in [0.05, 2.05]; one transfer per item.
//   cfg_if : index 0 pattern select, index 1 pillar spacing (Q0.16). Always ready.
//            Write only while no item is in flight.
// Throughput: one item per clock cycle while the output is not stalled.
// Pipeline: 67 register stages, every one with a valid bit: 3 stages of coordinate,
//   square and sum, 24 square-root stages (one root bit each), 17 angle CORDIC
//   stages, 2 phase stages, 18 sine/cosine CORDIC stages, 2 combine stages and
//   the output register.
// Stall: the whole pipeline advances together whenever the output register is
//   empty or being taken; while the receiver holds ready low the pipeline and
//   in_if.ready freeze, so nothing is dropped or repeated.
// Reset: valid bits clear, the pattern returns to ripple and the spacing
//   to 0.45; no clearing pass is needed.
module wave_pillar_height
  import wph_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  wph_in_if.sink    in_if,
  wph_out_if.source out_if,
  wph_cfg_if.sink   cfg_if
);

  // Configuration registers
  logic [PAT_W-1:0] pattern_q;
  logic [SPC_W-1:0] spacing_q;

  assign cfg_if.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pattern_q <= PAT_RIPPLE;
      spacing_q <= SPACING_RST;
    end else if (cfg_if.valid) begin
      case (cfg_if.index)
        REG_PATTERN: pattern_q <= cfg_if.data[PAT_W-1:0];
        REG_SPACING: spacing_q <= cfg_if.data[SPC_W-1:0];
        default: ;
      endcase
    end
  end

  // Global advance: hold everything while a result waits on a stalled receiver
  logic en;
  logic out_vld_q;

  assign en          = !out_vld_q || out_if.ready;
  assign in_if.ready = en;

  // Stage 1: centre the indices and scale by the spacing
  logic signed [CENT_W-1:0]      cent_x;
  logic signed [CENT_W-1:0]      cent_z;
  logic signed [CENT_W+SPC_W:0]  px;
  logic signed [CENT_W+SPC_W:0]  pz;
  logic                          vld1_q;
  logic signed [COORD_W-1:0]     cx1_q;
  logic signed [COORD_W-1:0]     cz1_q;
  logic [TIME_W-1:0]             t1_q;

  assign cent_x = $signed({{(CENT_W-IDX_W-1){1'b0}}, in_if.column_index, 1'b0})
                  - CENT_W'(GRID_DIM);
  assign cent_z = $signed({{(CENT_W-IDX_W-1){1'b0}}, in_if.row_index, 1'b0})
                  - CENT_W'(GRID_DIM);
  assign px = cent_x * $signed({1'b0, spacing_q});
  assign pz = cent_z * $signed({1'b0, spacing_q});

  // Stage 2: squares and coordinate sum
  logic signed [2*COORD_W-1:0] sqx;
  logic signed [2*COORD_W-1:0] sqz;
  logic                        vld2_q;
  item_t                       it2_q;
  logic [SQ_W-1:0]             sqx2_q;
  logic [SQ_W-1:0]             sqz2_q;

  assign sqx = cx1_q * cx1_q;
  assign sqz = cz1_q * cz1_q;

  // Stage 3: squared radius
  logic            vld3_q;
  item_t           it3_q;
  logic [SQ_W-1:0] rad3_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld1_q <= 1'b0;
      vld2_q <= 1'b0;
      vld3_q <= 1'b0;
    end else if (en) begin
      vld1_q <= in_if.valid;
      vld2_q <= vld1_q;
      vld3_q <= vld2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      cx1_q    <= px[COORD_W-1:0];
      cz1_q    <= pz[COORD_W-1:0];
      t1_q     <= in_if.time_value;
      it2_q.cx <= cx1_q;
      it2_q.cz <= cz1_q;
      it2_q.cs <= CS_W'(cx1_q) + CS_W'(cz1_q);
      it2_q.t  <= t1_q;
      sqx2_q   <= sqx[SQ_W-1:0];
      sqz2_q   <= sqz[SQ_W-1:0];
      it3_q    <= it2_q;
      rad3_q   <= sqx2_q + sqz2_q;
    end
  end

  // Radius
  logic              vld_r;
  logic [ROOT_W-1:0] root_r;
  item_t             it_r;
  geo_t              geo_r;

  wph_isqrt u_isqrt (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .vld_i  (vld3_q),
    .rad_i  (rad3_q),
    .side_i (it3_q),
    .vld_o  (vld_r),
    .root_o (root_r),
    .side_o (it_r)
  );

  assign geo_r.it = it_r;
  assign geo_r.d  = root_r;

  // Angle for the spiral
  logic            vld_a;
  geo_t            geo_a;
  logic [PH_W-1:0] ang_a;

  wph_atan u_atan (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .vld_i  (vld_r),
    .geo_i  (geo_r),
    .vld_o  (vld_a),
    .geo_o  (geo_a),
    .ang_o  (ang_a)
  );

  // Phase stage 1: pick operands per pattern, form the scaled terms
  logic signed [CS_W-1:0]      op0, op1, op2;
  logic [PH_W-1:0]             k0, k1, k2, kt0, kt1, kt2;
  logic signed [CS_W+PH_W:0]   cp0, cp1, cp2;
  logic [TIME_W+PH_W-1:0]      tp0, tp1, tp2;
  logic signed [CS_W-1:0]      d_ext, cx_ext, cz_ext;

  assign d_ext  = $signed({1'b0, geo_a.d});
  assign cx_ext = CS_W'(geo_a.it.cx);
  assign cz_ext = CS_W'(geo_a.it.cz);

  always_comb begin
    op0 = d_ext;
    k0  = K_2_0;
    op1 = '0;
    k1  = '0;
    op2 = '0;
    k2  = '0;
    kt0 = K_3_0;
    kt1 = '0;
    kt2 = '0;
    case (pattern_q)
      PAT_DIAGONAL: begin
        op0 = geo_a.it.cs;
        k0  = K_1_5;
        kt0 = K_2_5;
      end
      PAT_SPIRAL: begin
        k0  = K_1_2;
        kt0 = K_2_0;
      end
      PAT_CROSS: begin
        op0 = cx_ext;
        k0  = K_2_0;
        op1 = cz_ext;
        k1  = K_2_0;
        kt0 = K_2_5;
      end
      PAT_BREATH: begin
        k0  = K_1_5;
        kt0 = K_2_0;
        kt1 = K_0_5;
      end
      PAT_LAYERED: begin
        op0 = cx_ext;
        k0  = K_3_1;
        op1 = cz_ext;
        k1  = K_2_7;
        op2 = geo_a.it.cs;
        k2  = K_1_9;
        kt0 = K_1_7;
        kt1 = K_2_3;
        kt2 = K_3_1;
      end
      default: ;  // ripple, also for unknown codes
    endcase
  end

  assign cp0 = op0 * $signed({1'b0, k0});
  assign cp1 = op1 * $signed({1'b0, k1});
  assign cp2 = op2 * $signed({1'b0, k2});
  assign tp0 = geo_a.it.t * kt0;
  assign tp1 = geo_a.it.t * kt1;
  assign tp2 = geo_a.it.t * kt2;

  logic            vp1_q;
  logic [PH_W-1:0] c0_q, c1_q, c2_q, tt0_q, tt1_q, tt2_q, ang3_q;

  // Phase stage 2: combine terms, wrapping modulo one turn
  logic            vp2_q;
  logic [PH_W-1:0] ph0_q, ph1_q, ph2_q;
  logic [PH_W-1:0] ph0_d, ph1_d;

  always_comb begin
    ph0_d = c0_q - tt0_q;
    ph1_d = '0;
    case (pattern_q)
      PAT_SPIRAL:  ph0_d = ang3_q + c0_q - tt0_q;
      PAT_CROSS:   ph1_d = c1_q - tt0_q;
      PAT_BREATH:  ph1_d = tt1_q;
      PAT_LAYERED: ph1_d = c1_q + tt1_q;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vp1_q <= 1'b0;
      vp2_q <= 1'b0;
    end else if (en) begin
      vp1_q <= vld_a;
      vp2_q <= vp1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      c0_q   <= cp0[COORD_FRAC+PH_W-1:COORD_FRAC];
      c1_q   <= cp1[COORD_FRAC+PH_W-1:COORD_FRAC];
      c2_q   <= cp2[COORD_FRAC+PH_W-1:COORD_FRAC];
      tt0_q  <= tp0[TIME_FRAC+PH_W-1:TIME_FRAC];
      tt1_q  <= tp1[TIME_FRAC+PH_W-1:TIME_FRAC];
      tt2_q  <= tp2[TIME_FRAC+PH_W-1:TIME_FRAC];
      ang3_q <= ang_a + (ang_a << 1);
      ph0_q  <= ph0_d;
      ph1_q  <= ph1_d;
      ph2_q  <= c2_q - tt2_q;
    end
  end

  // Three sine/cosine units side by side
  logic                     vs0, vs1, vs2;
  logic signed [UNIT_W-1:0] s0, s1, c1, c2;

  wph_sincos u_sc0 (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .vld_i  (vp2_q),
    .ph_i   (ph0_q),
    .vld_o  (vs0),
    .sin_o  (s0),
    .cos_o  ()
  );

  wph_sincos u_sc1 (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .vld_i  (vp2_q),
    .ph_i   (ph1_q),
    .vld_o  (vs1),
    .sin_o  (s1),
    .cos_o  (c1)
  );

  wph_sincos u_sc2 (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .vld_i  (vp2_q),
    .ph_i   (ph2_q),
    .vld_o  (vs2),
    .sin_o  (),
    .cos_o  (c2)
  );

  // Combine stage 1: products of unit values
  logic                     vm1_q;
  logic signed [UNIT_W-1:0] s0_m1_q;
  logic signed [H_W-1:0]    prod_q, w1_q, w2_q;
  logic signed [UNIT_W-1:0] pair;

  assign pair = (pattern_q == PAT_CROSS) ? s1 : c1;

  // Combine stage 2: round, sum and saturate
  logic                     vm2_q;
  logic signed [UNIT_W-1:0] h_q;
  logic signed [H_W-1:0]    sum_h;
  logic signed [H_W-1:0]    h_raw;

  always_comb begin
    sum_h = (H_W'(s0_m1_q) <<< 15) + w1_q + w2_q + H_W'(32768);
    case (pattern_q)
      PAT_CROSS, PAT_BREATH: h_raw = (prod_q + H_W'(32768)) >>> 16;
      PAT_LAYERED:           h_raw = sum_h >>> 16;
      default:               h_raw = H_W'(s0_m1_q);
    endcase
  end

  // Output register: remap [-1, 1] to [0.05, 2.05] in Q2.12
  logic [HGT_W-1:0]      height_q;
  logic signed [H_W-1:0] h_off;

  assign h_off = (H_W'(h_q) + H_W'(65544)) >>> 4;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vm1_q     <= 1'b0;
      vm2_q     <= 1'b0;
      out_vld_q <= 1'b0;
    end else if (en) begin
      vm1_q     <= vs0 & vs1 & vs2;
      vm2_q     <= vm1_q;
      out_vld_q <= vm2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s0_m1_q  <= s0;
      prod_q   <= s0 * pair;
      w1_q     <= s1 * $signed(H_W'(19661));
      w2_q     <= c2 * $signed(H_W'(13107));
      h_q      <= clamp_unit(WIDE_W'(h_raw));
      height_q <= HGT_W'(h_off) + HGT_W'(205);
    end
  end

  assign out_if.valid         = out_vld_q;
  assign out_if.pillar_height = height_q;

endmodule

// ----- bench/tb.sv -----
// Self-checking bench for wave_pillar_height: directed corners, random phases, backpressure.
// Depends on wph_pkg, the wph_*_if interfaces and the wave_pillar_height RTL.
`timescale 1ns / 1ps

module tb;
  import wph_pkg::*;

  // Pipeline depth given at the head of the block, plus margin
  localparam int DRAIN_CYCLES = 100;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  wph_in_if  in_if ();
  wph_out_if out_if ();
  wph_cfg_if cfg_if ();

  wave_pillar_height dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_if  (in_if),
    .out_if (out_if),
    .cfg_if (cfg_if)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // Own copy of the two registers, updated on each config transfer
  logic [2:0]  pattern_sel;
  logic [15:0] spacing;

  logic [HGT_W-1:0] height_q[$];
  int errors = 0;
  bit idle_free = 1'b0;  // when set, neither side inserts gaps
  bit hold_go = 1'b0;
  logic hold_out = 1'b0;

  localparam logic [31:0] ATAN_STEP [16] = '{
    32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
    32'd42667331, 32'd21354465, 32'd10679838, 32'd5340245,
    32'd2670163, 32'd1335087, 32'd667544, 32'd333772,
    32'd166886, 32'd83443, 32'd41722, 32'd20861
  };

  // ---------------------------------------------------------------------------
  // Height predictor
  // ---------------------------------------------------------------------------

  function automatic longint sat_unit(longint v);
    if (v > 65536) return 65536;
    if (v < -65536) return -65536;
    return v;
  endfunction

  // floor(v * k / 2^f) mod 2^32, v may be negative
  function automatic logic [31:0] phase_term(longint v, logic [31:0] k, int f);
    logic [63:0] prod;
    logic [63:0] shifted;
    prod = v * longint'({32'b0, k});
    shifted = prod >> f;
    return shifted[31:0];
  endfunction

  function automatic longint int_root(logic [63:0] v);
    logic [63:0] res;
    logic [63:0] b;
    res = 0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= res + b) begin
        v = v - (res + b);
        res = (res >> 1) + b;
      end else begin
        res = res >> 1;
      end
      b = b >> 2;
    end
    return longint'(res);
  endfunction

  // Vectoring rotation; the origin gives zero turns
  function automatic logic [31:0] polar_angle(longint x, longint y);
    logic [31:0] z;
    longint dx, dy;
    z = 32'd0;
    if (x == 0 && y == 0) return 32'd0;
    if (x < 0) begin
      x = -x;
      y = -y;
      z = 32'h8000_0000;
    end
    for (int i = 0; i < 16; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (y > 0) begin
        x = x + dx; y = y - dy; z = z + ATAN_STEP[i];
      end else begin
        x = x - dx; y = y + dy; z = z - ATAN_STEP[i];
      end
    end
    return z;
  endfunction

  function automatic void rotate_unit(logic [31:0] ph, output longint s, output longint c);
    longint a, x, y, dx, dy;
    bit flip;
    flip = 1'b0;
    a = longint'({32'b0, ph});
    if (ph[31]) a = a - (64'sd1 <<< 32);
    x = 10188014;
    y = 0;
    if (a > 64'sd1073741824) begin
      a = 64'sd2147483648 - a; flip = 1'b1;
    end else if (a < -64'sd1073741824) begin
      a = -64'sd2147483648 - a; flip = 1'b1;
    end
    for (int i = 0; i < 16; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (a >= 0) begin
        x = x - dx; y = y + dy; a = a - longint'({32'b0, ATAN_STEP[i]});
      end else begin
        x = x + dx; y = y - dy; a = a + longint'({32'b0, ATAN_STEP[i]});
      end
    end
    s = sat_unit((y + 128) >>> 8);
    c = sat_unit((x + 128) >>> 8);
    if (flip) c = -c;
  endfunction

  function automatic longint sine_of(logic [31:0] ph);
    longint s, c;
    rotate_unit(ph, s, c);
    return s;
  endfunction

  function automatic longint cosine_of(logic [31:0] ph);
    longint s, c;
    rotate_unit(ph, s, c);
    return c;
  endfunction

  function automatic longint q16_mul(longint a, longint b);
    return (a * b + 32768) >>> 16;
  endfunction

  function automatic logic [HGT_W-1:0] predict_height(logic [4:0] col, logic [4:0] row,
                                                      logic [23:0] tv);
    longint cx, cz, d, t, h, hq;
    logic [31:0] p, q, r;
    t  = longint'({40'b0, tv});
    cx = (2 * longint'({59'b0, col}) - GRID_DIM) * longint'({48'b0, spacing});
    cz = (2 * longint'({59'b0, row}) - GRID_DIM) * longint'({48'b0, spacing});
    d  = int_root(cx * cx + cz * cz);
    case (pattern_sel)
      PAT_DIAGONAL: h = sine_of(phase_term(cx + cz, K_1_5, 17) - phase_term(t, K_2_5, 16));
      PAT_SPIRAL: begin
        p = 32'd3 * polar_angle(cx, cz) + phase_term(d, K_1_2, 17) - phase_term(t, K_2_0, 16);
        h = sine_of(p);
      end
      PAT_CROSS: begin
        q = phase_term(t, K_2_5, 16);
        h = q16_mul(sine_of(phase_term(cx, K_2_0, 17) - q),
                    sine_of(phase_term(cz, K_2_0, 17) - q));
      end
      PAT_BREATH: h = q16_mul(sine_of(phase_term(d, K_1_5, 17) - phase_term(t, K_2_0, 16)),
                              cosine_of(phase_term(t, K_0_5, 16)));
      PAT_LAYERED: begin
        p = phase_term(cx, K_3_1, 17) - phase_term(t, K_1_7, 16);
        q = phase_term(cz, K_2_7, 17) + phase_term(t, K_2_3, 16);
        r = phase_term(cx + cz, K_1_9, 17) - phase_term(t, K_3_1, 16);
        h = (32768 * sine_of(p) + 19661 * sine_of(q) + 13107 * cosine_of(r) + 32768) >>> 16;
      end
      // ripple, and the unknown codes that fall back to it
      default: h = sine_of(phase_term(d, K_2_0, 17) - phase_term(t, K_3_0, 16));
    endcase
    h = sat_unit(h);
    hq = 205 + ((h + 65536 + 8) >>> 4);
    return hq[HGT_W-1:0];
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------

  // Mostly no gap, some short, a few long
  function automatic int pick_gap();
    int r;
    if (idle_free) return 0;
    r = $urandom_range(0, 99);
    if (r < 70) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Offer one item, hold it until the transfer, predict, then maybe idle
  task automatic send_item(logic [4:0] col, logic [4:0] row, logic [23:0] tv);
    int gap;
    in_if.column_index = col;
    in_if.row_index    = row;
    in_if.time_value   = tv;
    in_if.valid        = 1'b1;
    do @(posedge clk_i); while (!in_if.ready);
    height_q.insert(height_q.size(), predict_height(col, row, tv));
    @(negedge clk_i);
    gap = pick_gap();
    if (gap > 0) begin
      in_if.valid = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
  endtask

  task automatic send_random(int count);
    for (int n = 0; n < count; n++)
      send_item(5'($urandom), 5'($urandom), 24'($urandom));
  endtask

  // Drain everything in flight, then wait out the pipeline before touching a register
  task automatic wait_drained();
    in_if.valid = 1'b0;
    wait (height_q.size() == 0);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    wait_drained();
    cfg_if.index = idx;
    cfg_if.data  = val;
    cfg_if.valid = 1'b1;
    do @(posedge clk_i); while (!cfg_if.ready);
    if (idx == REG_PATTERN) pattern_sel = val[2:0];
    else if (idx == REG_SPACING) spacing = val;
    @(negedge clk_i);
    cfg_if.valid = 1'b0;
  endtask

  // ---------------------------------------------------------------------------
  // Result side: random ready, long hold-off on request, checking
  // ---------------------------------------------------------------------------

  // Hold-off counted in its own process; the sink only watches hold_out
  initial begin
    forever begin
      wait (hold_go);
      @(negedge clk_i);
      hold_out <= 1'b1;
      repeat (400) @(negedge clk_i);
      hold_out <= 1'b0;
      hold_go = 1'b0;
    end
  end

  initial begin
    int stall;
    logic [HGT_W-1:0] want;
    stall = 0;
    forever begin
      @(posedge clk_i);
      if (out_if.valid && out_if.ready) begin
        if (height_q.size() == 0) begin
          $display("%0t: unexpected height %0d with none outstanding", $time,
                   out_if.pillar_height);
          errors++;
        end else begin
          want = height_q.pop_front();
          if (out_if.pillar_height !== want) begin
            $display("%0t: pillar_height expected %0d actual %0d", $time, want,
                     out_if.pillar_height);
            errors++;
          end
        end
      end
      @(negedge clk_i);
      if (stall == 0) stall = pick_gap();
      if (hold_out || stall > 0) begin
        out_if.ready = 1'b0;
        if (stall > 0) stall--;
      end else begin
        out_if.ready = 1'b1;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Field extremes, the grid centre (origin angle), every pattern and the unknown codes
  task automatic test_directed();
    logic [2:0] pats [8] = '{PAT_RIPPLE, PAT_DIAGONAL, PAT_SPIRAL, PAT_CROSS,
                             PAT_BREATH, PAT_LAYERED, 3'd0, 3'd7};
    write_reg(REG_PATTERN, 16'(PAT_RIPPLE));
    send_item(5'd0, 5'd0, 24'd0);
    send_item(5'd31, 5'd31, 24'hFF_FFFF);
    send_item(5'd0, 5'd31, 24'h80_0000);
    send_item(5'd16, 5'd16, 24'h01_0000);
    for (int i = 1; i < 8; i++) begin
      write_reg(REG_PATTERN, 16'(pats[i]));
      send_item(5'd16, 5'd16, 24'($urandom));
      send_item(5'd31, 5'd0, 24'hFF_FFFF);
    end
    // zero spacing puts every pillar at the centre; then the widest spacing
    write_reg(REG_PATTERN, 16'(PAT_SPIRAL));
    write_reg(REG_SPACING, 16'd0);
    send_item(5'd3, 5'd29, 24'h12_3456);
    write_reg(REG_SPACING, 16'hFFFF);
    send_item(5'd0, 5'd0, 24'hFF_FFFF);
    send_item(5'd31, 5'd31, 24'd0);
  endtask

  // One phase per setting, extremes of spacing among them
  task automatic test_random_phases();
    logic [15:0] spc;
    for (int ph = 0; ph < 8; ph++) begin
      case (ph % 4)
        0: spc = 16'd1;
        1: spc = 16'hFFFF;
        2: spc = SPACING_RST;
        default: spc = 16'($urandom_range(1, 65535));
      endcase
      write_reg(REG_PATTERN, 16'(ph == 7 ? $urandom_range(0, 7) : ph + 1));
      write_reg(REG_SPACING, spc);
      idle_free = (ph == 3);
      send_random(200);
      idle_free = 1'b0;
    end
  endtask

  // Receiver holds off long enough that the pipeline fills and stalls the input
  task automatic test_backpressure();
    write_reg(REG_PATTERN, 16'(PAT_LAYERED));
    write_reg(REG_SPACING, 16'($urandom));
    idle_free = 1'b1;
    hold_go = 1'b1;
    send_random(150);
    idle_free = 1'b0;
  endtask

  initial begin
    in_if.valid        = 1'b0;
    in_if.column_index = '0;
    in_if.row_index    = '0;
    in_if.time_value   = '0;
    out_if.ready       = 1'b0;
    cfg_if.valid       = 1'b0;
    cfg_if.index       = '0;
    cfg_if.data        = '0;
    pattern_sel        = PAT_RIPPLE;
    spacing            = SPACING_RST;
    repeat (12) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // reset values first, before any register write
    send_random(20);
    test_directed();
    test_random_phases();
    test_backpressure();

    wait_drained();
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  // Far beyond the slowest correct run
  initial begin
    #2000000;
    $display("DONE: errors detected");
    $finish;
  end

endmodule

// ----- sim.f -----
rtl/wph_pkg.sv
rtl/wph_if.sv
rtl/wph_isqrt.sv
rtl/wph_atan.sv
rtl/wph_sincos.sv
rtl/wave_pillar_height.sv
bench/tb.sv
